// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// File: rtl/cse_pkg.sv
`timescale 1ns / 1ps
package cse_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int IW = 64;
   localparam int DEF_FRAC_BITS = 16;
   localparam int DIV_BPS = 2;

   typedef logic signed [IW-1:0] word_type;

   localparam word_type LIMIT = word_type'({1'b0, {(IW-1){1'b1}}});

   typedef struct packed {
      word_type val;
      logic     ov;
   } sat_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] val;
      logic                  ov;
   } emit_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] query_x;
      logic signed [DATA_WIDTH-1:0] left_x;
      logic signed [DATA_WIDTH-1:0] right_x;
      logic signed [DATA_WIDTH-1:0] left_y;
      logic signed [DATA_WIDTH-1:0] right_y;
      logic signed [DATA_WIDTH-1:0] left_slope;
      logic signed [DATA_WIDTH-1:0] right_slope;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] spline_value;
      logic signed [DATA_WIDTH-1:0] first_derivative;
      logic signed [DATA_WIDTH-1:0] second_derivative;
      logic                         saturated;
      logic                         zero_interval;
   } rsp_type;

   // clamp an exact sum to the symmetric internal range
   function automatic sat_type sat_wide(input logic signed [IW:0] s);
      sat_type r;
      logic signed [IW:0] lim;
      lim = {2'b00, {(IW-1){1'b1}}};
      if (s > lim) begin
         r = '{LIMIT, 1'b1};
      end else if (s < -lim) begin
         r = '{-LIMIT, 1'b1};
      end else begin
         r = '{word_type'(s[IW-1:0]), 1'b0};
      end
      return r;
   endfunction

   function automatic sat_type sat_add(input word_type a, input word_type b);
      return sat_wide($signed({a[IW-1], a}) + $signed({b[IW-1], b}));
   endfunction

   function automatic sat_type sat_sub(input word_type a, input word_type b);
      return sat_wide($signed({a[IW-1], a}) - $signed({b[IW-1], b}));
   endfunction

   function automatic sat_type fetch(input logic signed [DATA_WIDTH-1:0] v);
      return sat_wide($signed({{(IW+1-DATA_WIDTH){v[DATA_WIDTH-1]}}, v}));
   endfunction

   function automatic emit_type emit(input word_type v);
      emit_type r;
      word_type hi;
      word_type lo;
      hi = word_type'({{(IW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
      lo = -hi - word_type'(1);
      if (v > hi) begin
         r = '{hi[DATA_WIDTH-1:0], 1'b1};
      end else if (v < lo) begin
         r = '{lo[DATA_WIDTH-1:0], 1'b1};
      end else begin
         r = '{v[DATA_WIDTH-1:0], 1'b0};
      end
      return r;
   endfunction

   // internal values never reach -2^(IW-1), so the magnitude fits IW-1 bits
   function automatic logic [IW-2:0] mag_of(input word_type v);
      word_type t;
      t = v[IW-1] ? -v : v;
      return t[IW-2:0];
   endfunction

endpackage

// File: rtl/cse_qmul.sv
`timescale 1ns / 1ps
module cse_qmul #(
   parameter int LANES     = 1,
   parameter int SIDE_W    = 1,
   parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  cse_pkg::word_type [LANES-1:0]    op_a,
   input  cse_pkg::word_type [LANES-1:0]    op_b,
   input  logic [SIDE_W-1:0]                side_in,
   output logic                             out_valid,
   output cse_pkg::word_type [LANES-1:0]    prod,
   output logic [LANES-1:0]                 prod_ov,
   output logic [SIDE_W-1:0]                side_out
);
   import cse_pkg::*;

   localparam int HW = IW / 2;
   localparam int PW = 2 * IW;
   localparam int MW = IW - 1;

   logic [3:0]              v_ff;
   logic [SIDE_W-1:0]       side_ff [0:3];
   logic [LANES-1:0]        neg_ff  [0:2];

   logic [LANES-1:0][MW-1:0] ma_ff, mb_ff;
   logic [LANES-1:0][IW-1:0] pp0_ff, pp1_ff, pp2_ff, pp3_ff;
   logic [LANES-1:0][IW-1:0] pp0_in, pp1_in, pp2_in, pp3_in;
   logic [LANES-1:0][PW-1:0] sum_ff, sum_in;
   word_type [LANES-1:0]     prod_ff, prod_in;
   logic [LANES-1:0]         ov_ff, ov_in;

   // partial products of 32-bit halves
   always_comb begin
      logic [HW-1:0] al, ah, bl, bh;
      for (int l = 0; l < LANES; l++) begin
         al = ma_ff[l][HW-1:0];
         ah = HW'(ma_ff[l][MW-1:HW]);
         bl = mb_ff[l][HW-1:0];
         bh = HW'(mb_ff[l][MW-1:HW]);
         pp0_in[l] = IW'(al) * IW'(bl);
         pp1_in[l] = IW'(al) * IW'(bh);
         pp2_in[l] = IW'(ah) * IW'(bl);
         pp3_in[l] = IW'(ah) * IW'(bh);
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         sum_in[l] = {{IW{1'b0}}, pp0_ff[l]}
                   + ({{IW{1'b0}}, pp1_ff[l]} << HW)
                   + ({{IW{1'b0}}, pp2_ff[l]} << HW)
                   + {pp3_ff[l], {IW{1'b0}}};
      end
   end

   // round half away from zero on the magnitude, then clamp
   always_comb begin
      logic [PW-1:0] sh;
      word_type      mag;
      for (int l = 0; l < LANES; l++) begin
         sh = (sum_ff[l] + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
         if (|sh[PW-1:MW]) begin
            mag = LIMIT;
            ov_in[l] = 1'b1;
         end else begin
            mag = word_type'({1'b0, sh[MW-1:0]});
            ov_in[l] = 1'b0;
         end
         prod_in[l] = neg_ff[2][l] ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            ma_ff[l]     <= mag_of(op_a[l]);
            mb_ff[l]     <= mag_of(op_b[l]);
            neg_ff[0][l] <= op_a[l][IW-1] ^ op_b[l][IW-1];
         end
         neg_ff[1]  <= neg_ff[0];
         neg_ff[2]  <= neg_ff[1];
         side_ff[0] <= side_in;
         for (int k = 1; k < 4; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         pp0_ff  <= pp0_in;
         pp1_ff  <= pp1_in;
         pp2_ff  <= pp2_in;
         pp3_ff  <= pp3_in;
         sum_ff  <= sum_in;
         prod_ff <= prod_in;
         ov_ff   <= ov_in;
      end
   end

   assign out_valid = v_ff[3];
   assign prod      = prod_ff;
   assign prod_ov   = ov_ff;
   assign side_out  = side_ff[3];

endmodule

// File: rtl/cse_qdiv.sv
`timescale 1ns / 1ps
module cse_qdiv #(
   parameter int LANES     = 1,
   parameter int SIDE_W    = 1,
   parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  cse_pkg::word_type [LANES-1:0]    num,
   input  cse_pkg::word_type [LANES-1:0]    den,
   input  logic [SIDE_W-1:0]                side_in,
   output logic                             out_valid,
   output cse_pkg::word_type [LANES-1:0]    quot,
   output logic [LANES-1:0]                 quot_ov,
   output logic [SIDE_W-1:0]                side_out
);
   import cse_pkg::*;

   localparam int MW    = IW - 1;
   localparam int PW    = 2 * IW;
   localparam int NSTEP = IW / DIV_BPS;

   // operand magnitudes
   logic                     p_v_ff;
   logic [SIDE_W-1:0]        p_side_ff;
   logic [LANES-1:0][MW-1:0] p_mn_ff, p_mm_ff;
   logic [LANES-1:0]         p_neg_ff, p_zero_ff;

   // scaled dividend with half divisor added
   logic                     dv_v_ff;
   logic [SIDE_W-1:0]        dv_side_ff;
   logic [LANES-1:0][IW-1:0] dv_hi_ff, dv_lo_ff, dv_hi_in, dv_lo_in;
   logic [LANES-1:0][MW-1:0] dv_mm_ff;
   logic [LANES-1:0]         dv_neg_ff, dv_zero_ff;

   // restoring steps, DIV_BPS quotient bits per stage
   logic [NSTEP:0]           st_v_ff;
   logic [SIDE_W-1:0]        st_side_ff [0:NSTEP];
   logic [LANES-1:0][IW-1:0] st_rem_ff  [0:NSTEP];
   logic [LANES-1:0][IW-1:0] st_rem_in  [0:NSTEP];
   logic [LANES-1:0][IW-1:0] st_lo_ff   [0:NSTEP];
   logic [LANES-1:0][IW-1:0] st_lo_in   [0:NSTEP];
   logic [LANES-1:0][IW-1:0] st_q_ff    [0:NSTEP];
   logic [LANES-1:0][IW-1:0] st_q_in    [0:NSTEP];
   logic [LANES-1:0][MW-1:0] st_mm_ff   [0:NSTEP];
   logic [LANES-1:0]         st_neg_ff  [0:NSTEP];
   logic [LANES-1:0]         st_zero_ff [0:NSTEP];
   logic [LANES-1:0]         st_big_ff  [0:NSTEP];
   logic [LANES-1:0]         big_in;

   logic                     o_v_ff;
   logic [SIDE_W-1:0]        o_side_ff;
   word_type [LANES-1:0]     o_q_ff, o_q_in;
   logic [LANES-1:0]         o_ov_ff, o_ov_in;

   always_comb begin
      logic [PW-1:0] dv;
      for (int l = 0; l < LANES; l++) begin
         dv = ({{(IW+1){1'b0}}, p_mn_ff[l]} << FRAC_BITS)
            + {{(IW+1){1'b0}}, 1'b0, p_mm_ff[l][MW-1:1]};
         dv_hi_in[l] = dv[PW-1:IW];
         dv_lo_in[l] = dv[IW-1:0];
      end
   end

   always_comb begin
      logic [IW:0]   r;
      logic [IW-1:0] lo;
      logic [IW-1:0] q;
      logic [IW:0]   dm;
      for (int l = 0; l < LANES; l++) begin
         // quotient overflows when the upper dividend word reaches the divisor
         big_in[l]       = dv_hi_ff[l] >= {1'b0, dv_mm_ff[l]};
         st_rem_in[0][l] = big_in[l] ? '0 : dv_hi_ff[l];
         st_lo_in[0][l]  = dv_lo_ff[l];
         st_q_in[0][l]   = '0;
      end
      for (int k = 1; k <= NSTEP; k++) begin
         for (int l = 0; l < LANES; l++) begin
            dm = {2'b00, st_mm_ff[k-1][l]};
            lo = st_lo_ff[k-1][l];
            q  = st_q_ff[k-1][l];
            r  = {1'b0, st_rem_ff[k-1][l]};
            for (int j = 0; j < DIV_BPS; j++) begin
               r  = {r[IW-1:0], lo[IW-1]};
               lo = {lo[IW-2:0], 1'b0};
               if (r >= dm) begin
                  r = r - dm;
                  q = {q[IW-2:0], 1'b1};
               end else begin
                  q = {q[IW-2:0], 1'b0};
               end
            end
            st_rem_in[k][l] = r[IW-1:0];
            st_lo_in[k][l]  = lo;
            st_q_in[k][l]   = q;
         end
      end
   end

   always_comb begin
      word_type mag;
      for (int l = 0; l < LANES; l++) begin
         if (st_zero_ff[NSTEP][l]) begin
            mag = '0;
            o_ov_in[l] = 1'b0;
         end else if (st_big_ff[NSTEP][l] || st_q_ff[NSTEP][l][IW-1]) begin
            mag = LIMIT;
            o_ov_in[l] = 1'b1;
         end else begin
            mag = word_type'(st_q_ff[NSTEP][l]);
            o_ov_in[l] = 1'b0;
         end
         o_q_in[l] = st_neg_ff[NSTEP][l] ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff  <= 1'b0;
         dv_v_ff <= 1'b0;
         st_v_ff <= '0;
         o_v_ff  <= 1'b0;
      end else if (en) begin
         p_v_ff  <= in_valid;
         dv_v_ff <= p_v_ff;
         st_v_ff <= {st_v_ff[NSTEP-1:0], dv_v_ff};
         o_v_ff  <= st_v_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            p_mn_ff[l]   <= mag_of(num[l]);
            p_mm_ff[l]   <= mag_of(den[l]);
            p_neg_ff[l]  <= num[l][IW-1] ^ den[l][IW-1];
            p_zero_ff[l] <= den[l] == '0;
         end
         p_side_ff     <= side_in;
         dv_side_ff    <= p_side_ff;
         dv_hi_ff      <= dv_hi_in;
         dv_lo_ff      <= dv_lo_in;
         dv_mm_ff      <= p_mm_ff;
         dv_neg_ff     <= p_neg_ff;
         dv_zero_ff    <= p_zero_ff;
         st_side_ff[0] <= dv_side_ff;
         st_mm_ff[0]   <= dv_mm_ff;
         st_neg_ff[0]  <= dv_neg_ff;
         st_zero_ff[0] <= dv_zero_ff;
         st_big_ff[0]  <= big_in;
         for (int k = 0; k <= NSTEP; k++) begin
            st_rem_ff[k] <= st_rem_in[k];
            st_lo_ff[k]  <= st_lo_in[k];
            st_q_ff[k]   <= st_q_in[k];
         end
         for (int k = 1; k <= NSTEP; k++) begin
            st_side_ff[k] <= st_side_ff[k-1];
            st_mm_ff[k]   <= st_mm_ff[k-1];
            st_neg_ff[k]  <= st_neg_ff[k-1];
            st_zero_ff[k] <= st_zero_ff[k-1];
            st_big_ff[k]  <= st_big_ff[k-1];
         end
         o_side_ff <= st_side_ff[NSTEP];
         o_q_ff    <= o_q_in;
         o_ov_ff   <= o_ov_in;
      end
   end

   assign out_valid = o_v_ff;
   assign quot      = o_q_ff;
   assign quot_ov   = o_ov_ff;
   assign side_out  = o_side_ff;

endmodule

// File: rtl/cubic_spline_segment_evaluator.sv
// Cubic Hermite segment evaluator, value and two derivatives per item.
// Pipeline: three dividers, three multiplier banks, seven single add stages and an
// output register between req accept and rsp valid.
// Throughput: one item per cycle; the whole pipeline freezes only while rsp is held.
// Reset clears every valid bit at once; no clearing pass, no state kept.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cubic_spline_segment_evaluator #(
   parameter int FRAC_BITS = cse_pkg::DEF_FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cse_pkg::rsp_type rsp_data
);
   import cse_pkg::*;

   localparam word_type ONE = word_type'(1) << FRAC_BITS;

   // side data carried past each arithmetic unit
   typedef struct packed {
      word_type h, d, y1, y2, k1, k2;
      logic     zero, ov;
   } sd1_type;
   typedef struct packed {
      word_type t, s, h, d, y1, y2, k1, k2;
      logic     zero, ov;
   } sdc_type;
   typedef struct packed {
      word_type t, s, h, d;
      logic     zero, ov;
   } sd2_type;
   typedef struct packed {
      word_type t, s, h, d, a, b, sy, w;
      logic     zero, ov;
   } sd3_type;
   typedef struct packed {
      word_type t, h, d, b, sy, w, m, a2, g, bma, smt;
      logic     zero, ov;
   } sde_type;
   typedef struct packed {
      word_type t, h, d, sy, w, m, bma, smt, e, g3;
      logic     zero, ov;
   } sdf_type;
   typedef struct packed {
      word_type h, d, sy, e;
      logic     zero, ov;
   } sd6_type;
   typedef struct packed {
      word_type h, val, der1, wbma, sec1;
      logic     zero, ov;
   } sdg_type;
   typedef struct packed {
      word_type h, val, der2, sec2;
      logic     zero, ov;
   } sdh_type;
   typedef struct packed {
      word_type h, val;
      logic     zero, ov;
   } sd9_type;
   typedef struct packed {
      word_type val, der;
      logic     zero, ov;
   } sd10_type;

   // whole pipeline advances unless a finished item is held at the output
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---- stage 1: load inputs, h = x2-x1, d = y2-y1, u = x-x1
   logic     s1_v_ff;
   word_type s1_u_ff, s1_u_in;
   sd1_type  s1_ff, s1_in;

   always_comb begin
      sat_type fx, fx1, fx2, fy1, fy2, fk1, fk2, h, d, u;
      fx  = fetch(req_data.query_x);
      fx1 = fetch(req_data.left_x);
      fx2 = fetch(req_data.right_x);
      fy1 = fetch(req_data.left_y);
      fy2 = fetch(req_data.right_y);
      fk1 = fetch(req_data.left_slope);
      fk2 = fetch(req_data.right_slope);
      h   = sat_sub(fx2.val, fx1.val);
      d   = sat_sub(fy2.val, fy1.val);
      u   = sat_sub(fx.val, fx1.val);
      s1_u_in = u.val;
      s1_in.h  = h.val;
      s1_in.d  = d.val;
      s1_in.y1 = fy1.val;
      s1_in.y2 = fy2.val;
      s1_in.k1 = fk1.val;
      s1_in.k2 = fk2.val;
      // raw compare: a zero interval bypasses all arithmetic at the output
      s1_in.zero = req_data.left_x == req_data.right_x;
      s1_in.ov   = fx.ov | fx1.ov | fx2.ov | fy1.ov | fy2.ov | fk1.ov | fk2.ov
                 | h.ov | d.ov | u.ov;
   end

   // ---- t = u / h
   logic                t_v;
   word_type [0:0]      t_q;
   logic [0:0]          t_ov;
   sd1_type             t_sd;

   cse_qdiv #(.LANES(1), .SIDE_W($bits(sd1_type)), .FRAC_BITS(FRAC_BITS)) u_div_t (
      .clock(clock), .reset(reset), .en(en), .in_valid(s1_v_ff),
      .num(s1_u_ff), .den(s1_ff.h), .side_in(s1_ff),
      .out_valid(t_v), .quot(t_q), .quot_ov(t_ov), .side_out(t_sd)
   );

   // ---- stage C: s = 1 - t
   logic    c_v_ff;
   sdc_type c_ff, c_in;

   always_comb begin
      sat_type s;
      s = sat_sub(ONE, t_q[0]);
      c_in.t  = t_q[0];
      c_in.s  = s.val;
      c_in.h  = t_sd.h;
      c_in.d  = t_sd.d;
      c_in.y1 = t_sd.y1;
      c_in.y2 = t_sd.y2;
      c_in.k1 = t_sd.k1;
      c_in.k2 = t_sd.k2;
      c_in.zero = t_sd.zero;
      c_in.ov   = t_sd.ov | t_ov[0] | s.ov;
   end

   // ---- products: k1*h, k2*h, s*y1, t*y2, t*s
   logic           m1_v;
   word_type [4:0] m1_p;
   logic [4:0]     m1_ov;
   sd2_type        m1_sd_in, m1_sd;

   assign m1_sd_in = '{t: c_ff.t, s: c_ff.s, h: c_ff.h, d: c_ff.d,
                       zero: c_ff.zero, ov: c_ff.ov};

   cse_qmul #(.LANES(5), .SIDE_W($bits(sd2_type)), .FRAC_BITS(FRAC_BITS)) u_mul_1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(c_v_ff),
      .op_a({c_ff.t, c_ff.t, c_ff.s, c_ff.k2, c_ff.k1}),
      .op_b({c_ff.s, c_ff.y2, c_ff.y1, c_ff.h, c_ff.h}),
      .side_in(m1_sd_in),
      .out_valid(m1_v), .prod(m1_p), .prod_ov(m1_ov), .side_out(m1_sd)
   );

   // ---- stage D: a = k1*h - d, b = d - k2*h, partial value s*y1 + t*y2
   logic    d_v_ff;
   sd3_type d_ff, d_in;

   always_comb begin
      sat_type a, b, sy;
      a  = sat_sub(m1_p[0], m1_sd.d);
      b  = sat_sub(m1_sd.d, m1_p[1]);
      sy = sat_add(m1_p[2], m1_p[3]);
      d_in.t  = m1_sd.t;
      d_in.s  = m1_sd.s;
      d_in.h  = m1_sd.h;
      d_in.d  = m1_sd.d;
      d_in.a  = a.val;
      d_in.b  = b.val;
      d_in.sy = sy.val;
      d_in.w  = m1_p[4];
      d_in.zero = m1_sd.zero;
      d_in.ov   = m1_sd.ov | (|m1_ov) | a.ov | b.ov | sy.ov;
   end

   // ---- products: a*s, b*t
   logic           m2_v;
   word_type [1:0] m2_p;
   logic [1:0]     m2_ov;
   sd3_type        m2_sd;

   cse_qmul #(.LANES(2), .SIDE_W($bits(sd3_type)), .FRAC_BITS(FRAC_BITS)) u_mul_2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(d_v_ff),
      .op_a({d_ff.b, d_ff.a}), .op_b({d_ff.t, d_ff.s}), .side_in(d_ff),
      .out_valid(m2_v), .prod(m2_p), .prod_ov(m2_ov), .side_out(m2_sd)
   );

   // ---- stage E: m = a*s + b*t, and the differences for the derivatives
   logic    e_v_ff;
   sde_type e_ff, e_in;

   always_comb begin
      sat_type m, a2, g, bma, smt;
      m   = sat_add(m2_p[0], m2_p[1]);
      a2  = sat_add(m2_sd.a, m2_sd.a);
      g   = sat_sub(m2_sd.a, m2_sd.b);
      bma = sat_sub(m2_sd.b, m2_sd.a);
      smt = sat_sub(m2_sd.s, m2_sd.t);
      e_in.t   = m2_sd.t;
      e_in.h   = m2_sd.h;
      e_in.d   = m2_sd.d;
      e_in.b   = m2_sd.b;
      e_in.sy  = m2_sd.sy;
      e_in.w   = m2_sd.w;
      e_in.m   = m.val;
      e_in.a2  = a2.val;
      e_in.g   = g.val;
      e_in.bma = bma.val;
      e_in.smt = smt.val;
      e_in.zero = m2_sd.zero;
      e_in.ov   = m2_sd.ov | (|m2_ov) | m.ov | a2.ov | g.ov | bma.ov | smt.ov;
   end

   // ---- stage F: e = b - 2a, g3 = 3*(a-b) as two saturating adds
   logic    f_v_ff;
   sdf_type f_ff, f_in;

   always_comb begin
      sat_type e, g2, g3;
      e  = sat_sub(e_ff.b, e_ff.a2);
      g2 = sat_add(e_ff.g, e_ff.g);
      g3 = sat_add(g2.val, e_ff.g);
      f_in.t   = e_ff.t;
      f_in.h   = e_ff.h;
      f_in.d   = e_ff.d;
      f_in.sy  = e_ff.sy;
      f_in.w   = e_ff.w;
      f_in.m   = e_ff.m;
      f_in.bma = e_ff.bma;
      f_in.smt = e_ff.smt;
      f_in.e   = e.val;
      f_in.g3  = g3.val;
      f_in.zero = e_ff.zero;
      f_in.ov   = e_ff.ov | e.ov | g2.ov | g3.ov;
   end

   // ---- products: w*m, (s-t)*m, w*(b-a), g3*t
   logic           m3_v;
   word_type [3:0] m3_p;
   logic [3:0]     m3_ov;
   sd6_type        m3_sd_in, m3_sd;

   assign m3_sd_in = '{h: f_ff.h, d: f_ff.d, sy: f_ff.sy, e: f_ff.e,
                       zero: f_ff.zero, ov: f_ff.ov};

   cse_qmul #(.LANES(4), .SIDE_W($bits(sd6_type)), .FRAC_BITS(FRAC_BITS)) u_mul_3 (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_v_ff),
      .op_a({f_ff.g3, f_ff.w, f_ff.smt, f_ff.w}),
      .op_b({f_ff.t, f_ff.bma, f_ff.m, f_ff.m}),
      .side_in(m3_sd_in),
      .out_valid(m3_v), .prod(m3_p), .prod_ov(m3_ov), .side_out(m3_sd)
   );

   // ---- stage G: value done, first terms of both derivative numerators
   logic    g_v_ff;
   sdg_type g_ff, g_in;

   always_comb begin
      sat_type val, der1, sec1;
      val  = sat_add(m3_sd.sy, m3_p[0]);
      der1 = sat_add(m3_sd.d, m3_p[1]);
      sec1 = sat_add(m3_sd.e, m3_p[3]);
      g_in.h    = m3_sd.h;
      g_in.val  = val.val;
      g_in.der1 = der1.val;
      g_in.wbma = m3_p[2];
      g_in.sec1 = sec1.val;
      g_in.zero = m3_sd.zero;
      g_in.ov   = m3_sd.ov | (|m3_ov) | val.ov | der1.ov | sec1.ov;
   end

   // ---- stage H: finish numerators
   logic    h_v_ff;
   sdh_type h_ff, h_in;

   always_comb begin
      sat_type der2, sec2;
      der2 = sat_add(g_ff.der1, g_ff.wbma);
      sec2 = sat_add(g_ff.sec1, g_ff.sec1);
      h_in.h    = g_ff.h;
      h_in.val  = g_ff.val;
      h_in.der2 = der2.val;
      h_in.sec2 = sec2.val;
      h_in.zero = g_ff.zero;
      h_in.ov   = g_ff.ov | der2.ov | sec2.ov;
   end

   // ---- first division by h for both derivatives
   logic           q2_v;
   word_type [1:0] q2_q;
   logic [1:0]     q2_ov;
   sd9_type        q2_sd_in, q2_sd;

   assign q2_sd_in = '{h: h_ff.h, val: h_ff.val, zero: h_ff.zero, ov: h_ff.ov};

   cse_qdiv #(.LANES(2), .SIDE_W($bits(sd9_type)), .FRAC_BITS(FRAC_BITS)) u_div_2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(h_v_ff),
      .num({h_ff.sec2, h_ff.der2}), .den({h_ff.h, h_ff.h}), .side_in(q2_sd_in),
      .out_valid(q2_v), .quot(q2_q), .quot_ov(q2_ov), .side_out(q2_sd)
   );

   // ---- second division by h for the curvature
   logic           q3_v;
   word_type [0:0] q3_q;
   logic [0:0]     q3_ov;
   sd10_type       q3_sd_in, q3_sd;

   assign q3_sd_in = '{val: q2_sd.val, der: q2_q[0], zero: q2_sd.zero,
                       ov: q2_sd.ov | (|q2_ov)};

   cse_qdiv #(.LANES(1), .SIDE_W($bits(sd10_type)), .FRAC_BITS(FRAC_BITS)) u_div_3 (
      .clock(clock), .reset(reset), .en(en), .in_valid(q2_v),
      .num(q2_q[1]), .den(q2_sd.h), .side_in(q3_sd_in),
      .out_valid(q3_v), .quot(q3_q), .quot_ov(q3_ov), .side_out(q3_sd)
   );

   // ---- output register: clamp to DATA_WIDTH, zero interval override
   logic    rsp_v_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      emit_type ev, ed, es;
      ev = emit(q3_sd.val);
      ed = emit(q3_sd.der);
      es = emit(q3_q[0]);
      if (q3_sd.zero) begin
         rsp_in = '{spline_value: '0, first_derivative: '0, second_derivative: '0,
                    saturated: 1'b0, zero_interval: 1'b1};
      end else begin
         rsp_in.spline_value      = ev.val;
         rsp_in.first_derivative  = ed.val;
         rsp_in.second_derivative = es.val;
         rsp_in.saturated         = q3_sd.ov | q3_ov[0] | ev.ov | ed.ov | es.ov;
         rsp_in.zero_interval     = 1'b0;
      end
   end

   // valid bits: reset clears, enable shifts
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         c_v_ff   <= 1'b0;
         d_v_ff   <= 1'b0;
         e_v_ff   <= 1'b0;
         f_v_ff   <= 1'b0;
         g_v_ff   <= 1'b0;
         h_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff  <= req_valid;
         c_v_ff   <= t_v;
         d_v_ff   <= m1_v;
         e_v_ff   <= m2_v;
         f_v_ff   <= e_v_ff;
         g_v_ff   <= m3_v;
         h_v_ff   <= g_v_ff;
         rsp_v_ff <= q3_v;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (en) begin
         s1_u_ff <= s1_u_in;
         s1_ff   <= s1_in;
         c_ff    <= c_in;
         d_ff    <= d_in;
         e_ff    <= e_in;
         f_ff    <= f_in;
         g_ff    <= g_in;
         h_ff    <= h_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLY(a_zero_interval_clean, clock, reset, rsp_valid && rsp_data.zero_interval, rsp_data.spline_value == 0 && rsp_data.first_derivative == 0 && rsp_data.second_derivative == 0 && !rsp_data.saturated, "zero interval item with nonzero outputs")
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled with empty output register")
   `ASSERT_ALWAYS(a_drain_clears, clock, reset, (rsp_valid && rsp_ready && !q3_v) |=> !rsp_valid, "output item repeated after it was taken")

endmodule

// File: test/cse_checker.sv
`timescale 1ns / 1ps
module cse_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cse_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cse_pkg::rsp_type rsp_data,
   output int               errors,
   output int               pending
);
   import cse_pkg::*;

   localparam int FB = DEF_FRAC_BITS;
   typedef logic signed [63:0] q64;
   localparam q64 QMAX = 64'sh7fff_ffff_ffff_ffff;

   rsp_type spline_q[$];
   logic    clip;

   initial errors = 0;
   assign pending = spline_q.size();

   // exact sum, then symmetric clamp
   function automatic q64 clamp(input logic signed [65:0] v);
      logic signed [65:0] lim;
      lim = {2'b00, QMAX};
      if (v > lim) begin
         clip = 1'b1;
         return QMAX;
      end
      if (v < -lim) begin
         clip = 1'b1;
         return -QMAX;
      end
      return v[63:0];
   endfunction

   function automatic q64 add_q(input q64 a, input q64 b);
      return clamp(66'(a) + 66'(b));
   endfunction

   function automatic q64 sub_q(input q64 a, input q64 b);
      return clamp(66'(a) - 66'(b));
   endfunction

   function automatic q64 sign_mag(input logic neg, input logic [127:0] mag);
      logic [63:0] m;
      if (mag > 128'(QMAX)) begin
         clip = 1'b1;
         m = QMAX;
      end else begin
         m = mag[63:0];
      end
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // product rounded half away from zero
   function automatic q64 mul_q(input q64 a, input q64 b);
      logic [127:0] ma, mb, p;
      ma = 128'(a < 0 ? -a : a);
      mb = 128'(b < 0 ? -b : b);
      p = ma * mb + (128'd1 << (FB - 1));
      return sign_mag((a < 0) != (b < 0), p >> FB);
   endfunction

   // quotient rounded half away from zero; zero divisor gives zero
   function automatic q64 div_q(input q64 n, input q64 m);
      logic [127:0] mn, mm, p;
      mn = 128'(n < 0 ? -n : n);
      mm = 128'(m < 0 ? -m : m);
      if (mm == 0) return 64'sd0;
      p = (mn << FB) + (mm >> 1);
      return sign_mag((n < 0) != (m < 0), p / mm);
   endfunction

   function automatic logic signed [31:0] to_out(input q64 v);
      if (v > 64'sh7fff_ffff) begin
         clip = 1'b1;
         return 32'sh7fff_ffff;
      end
      if (v < -64'sh8000_0000) begin
         clip = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic rsp_type hermite_eval(input req_type r);
      rsp_type o;
      q64 x, x1, x2, y1, y2, k1, k2, h, d, t, s, a, b, m, w, v, dv, e, g, f, c;
      o = '0;
      if (r.left_x == r.right_x) begin
         o.zero_interval = 1'b1;
         return o;
      end
      clip = 1'b0;
      x = 64'(r.query_x);   x1 = 64'(r.left_x);  x2 = 64'(r.right_x);
      y1 = 64'(r.left_y);   y2 = 64'(r.right_y);
      k1 = 64'(r.left_slope); k2 = 64'(r.right_slope);
      h = sub_q(x2, x1);
      d = sub_q(y2, y1);
      t = div_q(sub_q(x, x1), h);
      s = sub_q(64'sd1 <<< FB, t);
      a = sub_q(mul_q(k1, h), d);
      b = sub_q(d, mul_q(k2, h));
      m = add_q(mul_q(a, s), mul_q(b, t));
      w = mul_q(t, s);
      v = add_q(add_q(mul_q(s, y1), mul_q(t, y2)), mul_q(w, m));
      dv = add_q(d, mul_q(sub_q(s, t), m));
      dv = add_q(dv, mul_q(w, sub_q(b, a)));
      dv = div_q(dv, h);
      e = sub_q(b, add_q(a, a));
      g = sub_q(a, b);
      f = mul_q(add_q(add_q(g, g), g), t);
      c = add_q(e, f);
      c = add_q(c, c);
      c = div_q(div_q(c, h), h);
      o.spline_value = to_out(v);
      o.first_derivative = to_out(dv);
      o.second_derivative = to_out(c);
      o.saturated = clip;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (req_valid && req_ready) spline_q.push_back(hermite_eval(req_data));
         if (rsp_valid && rsp_ready) begin
            if (spline_q.size() == 0) begin
               errors <= errors + 1;
               $display("%0t: unexpected item %h", $time, rsp_data);
            end else begin
               exp_rsp = spline_q.pop_front();
               if (rsp_data !== exp_rsp) begin
                  errors <= errors + 1;
                  $display("%0t: mismatch val exp %h got %h, der exp %h got %h",
                           $time, exp_rsp.spline_value, rsp_data.spline_value,
                           exp_rsp.first_derivative, rsp_data.first_derivative);
                  $display("%0t:   curv exp %h got %h, sat exp %b got %b, zi exp %b got %b",
                           $time, exp_rsp.second_derivative, rsp_data.second_derivative,
                           exp_rsp.saturated, rsp_data.saturated,
                           exp_rsp.zero_interval, rsp_data.zero_interval);
               end
            end
         end
      end
   end
endmodule

// File: test/tb_cubic_spline_segment_evaluator.sv
`timescale 1ns / 1ps
module tb_cubic_spline_segment_evaluator;
   import cse_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      errors;
   int      pending;
   logic    calm = 1'b0;   // no idling on either side while set

   cubic_spline_segment_evaluator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   cse_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .errors(errors), .pending(pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stalls about 27% of cycles outside calm stretches
   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb_cubic_spline_segment_evaluator: FAIL");
      $finish;
   end

   // field value: full range, small Q16.16, moderate, or an extreme
   function automatic logic [31:0] pick_word();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         2: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
         default: begin
            case ($urandom_range(4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'h1;
               default: return 32'hffff_ffff;
            endcase
         end
      endcase
   endfunction

   // well-formed segment: left knot below right, query mostly inside
   function automatic req_type make_segment();
      req_type r;
      logic [31:0] span;
      r.left_x = 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
      span = ($urandom_range(9) == 0) ? $urandom_range(1, 32'h3fff_ffff)
                                      : $urandom_range(1 << 12, 1 << 20);
      r.right_x = r.left_x + span;
      r.query_x = ($urandom_range(9) == 0) ? pick_word()
                                           : r.left_x + $urandom_range(0, span);
      r.left_y = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      r.right_y = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      r.left_slope = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      r.right_slope = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      return r;
   endfunction

   // ready is stable between edges, so checking it at the falling edge
   // gives its value at the next rising edge
   task automatic send_item(input req_type r);
      if (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      req_type r;
      int cnt;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero interval, knots, extremes, tiny interval
      r = make_segment();
      r.right_x = r.left_x;
      send_item(r);
      r = '1;                                  // all -1: zero interval too
      send_item(r);
      r = make_segment(); r.query_x = r.left_x;  send_item(r);
      r = make_segment(); r.query_x = r.right_x; send_item(r);
      r = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      send_item(r);
      r = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      send_item(r);
      // interval of one LSB: quotients blow up and saturate
      r = make_segment(); r.right_x = r.left_x + 1; send_item(r);
      r.query_x = 32'h7fff_ffff; send_item(r);
      // descending segment, negative interval
      r = make_segment(); r.right_x = r.left_x - 32'h0001_0000; send_item(r);
      r = '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0};
      send_item(r);
      r = '{32'h0000_8000, 32'h0, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff};
      send_item(r);
      r = '{32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
      send_item(r);

      // hold off until the pipeline has drained
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // random part; a calm stretch in the middle
      for (cnt = 0; cnt < 1340; cnt++) begin
         if (cnt == 500) calm <= 1'b1;
         if (cnt == 700) calm <= 1'b0;
         case ($urandom_range(19))
            0: begin
               r = make_segment();
               r.right_x = r.left_x;
            end
            1, 2, 3: r = '{pick_word(), pick_word(), pick_word(), pick_word(),
                            pick_word(), pick_word(), pick_word()};
            default: r = make_segment();
         endcase
         send_item(r);
      end
      req_valid <= 1'b0;
      calm <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_cubic_spline_segment_evaluator: PASS");
      end else begin
         $display("tb_cubic_spline_segment_evaluator: FAIL");
      end
      $finish;
   end
endmodule
